/* rtl/assert_macros.svh */
// Concurrent assertion helpers, clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/samdu_pkg.sv */
package samdu_pkg;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

endpackage

/* rtl/signed_add_mul_div_unit_core.sv */
// Signed add / subtract / multiply / divide unit on WIDTH-bit two's-complement
// operands, one result per request. Add and subtract go through the ALU state
// into the output register. Multiply (shift-add, low WIDTH bits kept) and divide
// (restoring, quotient truncated toward zero, 0 on divide by zero) run the
// magnitude steps MAGA and MAGB, WIDTH iterations and one sign fix-up,
// all on a single shared adder/subtractor. Divide by zero skips the
// iterations. The unit takes a new request only when idle; the result sits
// in an output register, so a request may be accepted while the previous
// result still waits.
`include "assert_macros.svh"

module signed_add_mul_div_unit_core #(
  parameter int WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_action,
  input  logic signed [WIDTH-1:0] in_operand_a,
  input  logic signed [WIDTH-1:0] in_operand_b,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [WIDTH-1:0] out_result
);

  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALU,
    S_MAGA,
    S_MAGB,
    S_ITER,
    S_SIGN
  } state_t;

  state_t               state_r, state_nxt;
  samdu_pkg::action_t   act_r, act_nxt;
  logic [WIDTH-1:0]     acc_r, acc_nxt;
  logic [WIDTH-1:0]     x_r, x_nxt;
  logic [WIDTH-1:0]     y_r, y_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic                 zero_r, zero_nxt;
  logic [WIDTH-1:0]     out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // shared adder/subtractor
  logic [WIDTH-1:0]     add_a, add_b;
  logic                 add_sub;
  logic [WIDTH:0]       add_sum;

  logic                 accept;
  logic                 out_free;
  logic [WIDTH-1:0]     rem_shift;
  logic [WIDTH-1:0]     fix_base;

  assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {WIDTH{add_sub}}} + {{WIDTH{1'b0}}, add_sub};

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  assign rem_shift = {acc_r[WIDTH-2:0], y_r[WIDTH-1]};
  assign fix_base  = (act_r == samdu_pkg::ACT_MUL) ? acc_r : y_r;

  always_comb begin
    add_a   = '0;
    add_b   = x_r;
    add_sub = 1'b1;
    case (state_r)
      S_ALU: begin
        add_a   = x_r;
        add_b   = y_r;
        add_sub = (act_r == samdu_pkg::ACT_SUB);
      end
      S_MAGA: begin
        add_b = x_r;
      end
      S_MAGB: begin
        add_b = y_r;
      end
      S_ITER: begin
        if (act_r == samdu_pkg::ACT_MUL) begin
          add_a   = acc_r;
          add_b   = x_r;
          add_sub = 1'b0;
        end else begin
          add_a = rem_shift;
          add_b = x_r;
        end
      end
      S_SIGN: begin
        add_b = fix_base;
      end
      default: begin
        add_b = x_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    acc_nxt       = acc_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    zero_nxt      = zero_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt  = samdu_pkg::action_t'(in_action);
          x_nxt    = in_operand_a;
          y_nxt    = in_operand_b;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          neg_nxt  = in_operand_a[WIDTH-1] ^ in_operand_b[WIDTH-1];
          zero_nxt = (in_operand_b == '0);
          if (in_action == samdu_pkg::ACT_ADD || in_action == samdu_pkg::ACT_SUB) begin
            state_nxt = S_ALU;
          end else begin
            state_nxt = S_MAGA;
          end
        end
      end
      S_ALU: begin
        if (out_free) begin
          out_nxt       = add_sum[WIDTH-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_MAGA: begin
        if (x_r[WIDTH-1]) begin
          x_nxt = add_sum[WIDTH-1:0];
        end
        state_nxt = S_MAGB;
      end
      S_MAGB: begin
        if (y_r[WIDTH-1]) begin
          y_nxt = add_sum[WIDTH-1:0];
        end
        // swap so the divisor sits in x and the dividend in y
        if (act_r == samdu_pkg::ACT_DIV) begin
          x_nxt = y_r[WIDTH-1] ? add_sum[WIDTH-1:0] : y_r;
          y_nxt = x_r;
        end
        if (act_r == samdu_pkg::ACT_DIV && zero_r) begin
          state_nxt = S_SIGN;
        end else begin
          state_nxt = S_ITER;
        end
      end
      S_ITER: begin
        if (act_r == samdu_pkg::ACT_MUL) begin
          if (y_r[0]) begin
            acc_nxt = add_sum[WIDTH-1:0];
          end
          x_nxt = {x_r[WIDTH-2:0], 1'b0};
          y_nxt = {1'b0, y_r[WIDTH-1:1]};
        end else begin
          // carry out set: shifted remainder >= divisor
          acc_nxt = add_sum[WIDTH] ? add_sum[WIDTH-1:0] : rem_shift;
          y_nxt   = {y_r[WIDTH-2:0], add_sum[WIDTH]};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          if (act_r == samdu_pkg::ACT_DIV && zero_r) begin
            out_nxt = '0;
          end else if (neg_r) begin
            out_nxt = add_sum[WIDTH-1:0];
          end else begin
            out_nxt = fix_base;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r  <= act_nxt;
    acc_r  <= acc_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    out_r  <= out_nxt;
  end

  `ASSERT_NXT(a_accept_busy, accept, state_r != S_IDLE)
  `ASSERT_IMP(a_rem_below_dvs, state_r == S_ITER && act_r == samdu_pkg::ACT_DIV, acc_r < x_r)
  `ASSERT_NXT(a_wait_for_out, (state_r == S_ALU || state_r == S_SIGN) && out_valid_r && out_stall, state_r == $past(state_r))

endmodule

/* tb/signed_add_mul_div_unit_checker.sv */
`timescale 1ns / 1ps

module signed_add_mul_div_unit_checker #(
  parameter int WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [1:0]              in_action,
  input  logic signed [WIDTH-1:0] in_operand_a,
  input  logic signed [WIDTH-1:0] in_operand_b,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [WIDTH-1:0] out_result,
  output int                      fail_count,
  output int                      results_due
);

  typedef struct {
    samdu_pkg::action_t      act;
    logic signed [WIDTH-1:0] a;
    logic signed [WIDTH-1:0] b;
    logic signed [WIDTH-1:0] result;
  } arith_request_t;

  arith_request_t queued_results[$];
  int             fault_total = 0;

  function automatic logic signed [WIDTH-1:0] signed_op_result(
    input samdu_pkg::action_t act, input logic signed [WIDTH-1:0] a,
    input logic signed [WIDTH-1:0] b);
    logic signed [2*WIDTH-1:0] wide_a;
    logic signed [2*WIDTH-1:0] wide_b;
    logic signed [2*WIDTH-1:0] product;
    logic [WIDTH:0]            mag_a;
    logic [WIDTH:0]            mag_b;
    logic [WIDTH:0]            quo;
    logic signed [WIDTH-1:0]   r;
    wide_a = a;
    wide_b = b;
    // one extra bit so the most-negative operand has a true magnitude
    mag_a = a[WIDTH-1] ? (~{1'b1, a} + 1'b1) : {1'b0, a};
    mag_b = b[WIDTH-1] ? (~{1'b1, b} + 1'b1) : {1'b0, b};
    case (act)
      samdu_pkg::ACT_ADD: r = a + b;
      samdu_pkg::ACT_SUB: r = a - b;
      samdu_pkg::ACT_MUL: begin
        product = wide_a * wide_b;
        r = product[WIDTH-1:0];
      end
      samdu_pkg::ACT_DIV: begin
        if (b == '0) begin
          r = '0;
        end else begin
          quo = mag_a / mag_b;
          if (a[WIDTH-1] ^ b[WIDTH-1]) quo = -quo;
          r = quo[WIDTH-1:0];
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    arith_request_t due;
    arith_request_t req;
    if (rst_n) begin
      // retire before taking the new request, so a result can never match itself
      if (out_valid && !out_stall) begin
        if (queued_results.size() == 0) begin
          $display("%0t: result %0d with no request outstanding", $time, out_result);
          fault_total++;
        end else begin
          due = queued_results.pop_front();
          if (out_result !== due.result) begin
            $display("%0t: %s %0d, %0d: expected %0d, got %0d", $time, due.act.name(),
                     due.a, due.b, due.result, out_result);
            fault_total++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        req.act    = samdu_pkg::action_t'(in_action);
        req.a      = in_operand_a;
        req.b      = in_operand_b;
        req.result = signed_op_result(req.act, req.a, req.b);
        queued_results.push_back(req);
      end
    end
    fail_count  <= fault_total;
    results_due <= queued_results.size();
  end

endmodule

/* tb/signed_add_mul_div_unit_core_tb.sv */
`timescale 1ns / 1ps

module signed_add_mul_div_unit_core_tb;

  localparam int WIDTH = 32;
  localparam logic signed [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic signed [WIDTH-1:0] MOST_POS = ~MOST_NEG;
  localparam int RANDOM_REQUESTS = 550;
  localparam int LONG_HOLD = 300;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              in_action;
  logic signed [WIDTH-1:0] in_operand_a;
  logic signed [WIDTH-1:0] in_operand_b;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [WIDTH-1:0] out_result;
  int                      checker_faults;
  int                      results_due;
  logic                    no_idle = 1'b0;

  signed_add_mul_div_unit_core #(.WIDTH(WIDTH)) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result   (out_result)
  );

  signed_add_mul_div_unit_checker #(.WIDTH(WIDTH)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result   (out_result),
    .fail_count   (checker_faults),
    .results_due  (results_due)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic signed [WIDTH-1:0] pick_operand();
    case ($urandom_range(7, 0))
      0: begin
        case ($urandom_range(5, 0))
          0: return '0;
          1: return 1;
          2: return -1;
          3: return MOST_NEG;
          4: return MOST_POS;
          default: return -2;
        endcase
      end
      1, 2: return $signed($urandom_range(64, 0)) - 32;
      3: return {{(WIDTH-16){1'b0}}, 16'($urandom())} - (1 << 15);
      default: return $urandom();
    endcase
  endfunction

  // hold the request until a clock edge sees it accepted
  task automatic offer_request(input samdu_pkg::action_t act,
                               input logic signed [WIDTH-1:0] a,
                               input logic signed [WIDTH-1:0] b);
    int unsigned gap;
    logic        taken;
    gap = no_idle ? 0 : $urandom_range(19, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_operand_a <= a;
    in_operand_b <= b;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  initial begin : stimulus
    samdu_pkg::action_t act;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_action    <= samdu_pkg::ACT_ADD;
    in_operand_a <= '0;
    in_operand_b <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_request(samdu_pkg::ACT_ADD, MOST_POS, MOST_POS);
    offer_request(samdu_pkg::ACT_ADD, MOST_NEG, MOST_NEG);
    offer_request(samdu_pkg::ACT_ADD, MOST_NEG, -1);
    offer_request(samdu_pkg::ACT_ADD, 0, 0);
    offer_request(samdu_pkg::ACT_SUB, MOST_NEG, 1);
    offer_request(samdu_pkg::ACT_SUB, MOST_POS, -1);
    offer_request(samdu_pkg::ACT_SUB, 0, MOST_NEG);
    offer_request(samdu_pkg::ACT_MUL, MOST_POS, MOST_POS);
    offer_request(samdu_pkg::ACT_MUL, MOST_NEG, MOST_NEG);
    offer_request(samdu_pkg::ACT_MUL, MOST_NEG, -1);
    offer_request(samdu_pkg::ACT_MUL, MOST_NEG, 1);
    offer_request(samdu_pkg::ACT_MUL, -1, -1);
    offer_request(samdu_pkg::ACT_MUL, 0, MOST_NEG);
    offer_request(samdu_pkg::ACT_DIV, 12345, 0);
    offer_request(samdu_pkg::ACT_DIV, MOST_NEG, 0);
    offer_request(samdu_pkg::ACT_DIV, MOST_NEG, -1);
    offer_request(samdu_pkg::ACT_DIV, MOST_NEG, 1);
    offer_request(samdu_pkg::ACT_DIV, 7, -2);
    offer_request(samdu_pkg::ACT_DIV, -7, 2);
    offer_request(samdu_pkg::ACT_DIV, -7, -2);
    offer_request(samdu_pkg::ACT_DIV, MOST_POS, MOST_NEG);
    offer_request(samdu_pkg::ACT_DIV, MOST_NEG, MOST_POS);
    offer_request(samdu_pkg::ACT_DIV, 0, -5);
    offer_request(samdu_pkg::ACT_DIV, 5, 7);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 150) no_idle = 1'b1;
      if (i == 230) no_idle = 1'b0;
      if (i == 300) begin
        // drain completely before carrying on
        in_valid <= 1'b0;
        @(negedge clk);
        wait (results_due == 0);
        @(posedge clk);
      end
      act = samdu_pkg::action_t'($urandom_range(3, 0));
      offer_request(act, pick_operand(), pick_operand());
    end
    in_valid <= 1'b0;

    @(negedge clk);
    wait (results_due == 0);
    repeat (50) @(posedge clk);
    if (checker_faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : result_sink
    int          hold;
    int          accepted;
    logic        got;
    accepted = 0;
    out_stall <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (accepted == 60) hold = LONG_HOLD;
      else hold = no_idle ? 0 : $urandom_range(19, 0);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        got = out_valid;
        @(posedge clk);
      end while (!got);
      accepted++;
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
